// ----- src/tfr_pkg.sv -----
package tfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 100;
  localparam int unsigned NUM_VALS        = 5;
  localparam int unsigned OUT_DATA_W      = 192;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SEP   = 8'h3B;  // ';'
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [31:0] TAG_ID = "OBC4";

  typedef logic [NUM_VALS-1:0][31:0] tfr_vals_t;

  // index 0 is TCOB, up to DATA at the top
  localparam tfr_vals_t VALUE_TAGS = {"DATA", "STEB", "STOB", "TCEB", "TCOB"};

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_CKS  = 2'd2,
    PH_DONE = 2'd3
  } tfr_phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_MISSING  = 2'd2
  } tfr_status_e;

  typedef struct packed {
    logic clear;
    logic finish;
    logic take;
  } tfr_tok_ctrl_t;

endpackage

// ----- src/tfr_shadow.sv -----
module tfr_shadow
  import tfr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    byte_i,
  input  tfr_tok_ctrl_t ctrl_i,
  output tfr_vals_t     vals_o,
  output logic [5:0]    mask_o
);

  logic [3:0]      pos_q, pos_d;
  logic [3:0][7:0] tag_q, tag_d;
  logic [3:0][7:0] val_q, val_d;
  tfr_vals_t       vals_q, vals_d;
  logic [5:0]      mask_q, mask_d;

  always_comb begin
    pos_d  = pos_q;
    tag_d  = tag_q;
    val_d  = val_q;
    vals_d = vals_q;
    mask_d = mask_q;
    if (ctrl_i.clear) begin
      pos_d  = '0;
      tag_d  = '0;
      val_d  = '0;
      vals_d = '0;
      mask_d = '0;
    end else if (ctrl_i.finish) begin
      // a tag shorter than four chars matches nothing
      if (pos_q >= 4'd4) begin
        if (tag_q == TAG_ID) begin
          mask_d[0] = 1'b1;
        end else begin
          for (int k = 0; k < NUM_VALS; k++) begin
            if (tag_q == VALUE_TAGS[k]) begin
              vals_d[k]     = val_q;
              mask_d[k + 1] = 1'b1;
            end
          end
        end
      end
      pos_d = '0;
      tag_d = '0;
      val_d = '0;
    end else if (ctrl_i.take) begin
      if (pos_q < 4'd4) begin
        tag_d[2'(4'd3 - pos_q)] = byte_i;
      end else if (pos_q >= 4'd5 && pos_q <= 4'd8) begin
        val_d[2'(4'd8 - pos_q)] = byte_i;
      end
      // saturate past the value field
      if (pos_q < 4'd9) begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      tag_q  <= '0;
      val_q  <= '0;
      vals_q <= '0;
      mask_q <= '0;
    end else begin
      pos_q  <= pos_d;
      tag_q  <= tag_d;
      val_q  <= val_d;
      vals_q <= vals_d;
      mask_q <= mask_d;
    end
  end

  assign vals_o = vals_q;
  assign mask_o = mask_q;

endmodule

// ----- src/tagged_frame_receiver_xor_check.sv -----
// Tagged frame receiver with XOR checksum.
// Slave stream: one received serial byte per word on s_axis_tdata.
// Master stream: one status word per frame end; a frame ends on CR LF or
// once MAX_FRAME_BYTES bytes have been taken. Bytes between '$' and '*' are
// XORed and compared with the byte after '*'; tagged tokens fill shadow
// registers that are committed to the latched text fields only on a match.
// Timing: a status word appears on the master side the cycle after the byte
// that ends its frame. Sustained rate is one byte per cycle while no status
// word stalls, set by the single state update per accepted byte.
// Stall: the result register holds one status word; while it waits and
// m_axis_tready is low, s_axis_tready drops and no byte is taken. Bytes
// that end no frame are still taken while a status word waits only when
// the master side is ready, so one stalled word stops the input.
// Reset: all frame, shadow and committed state clears, the output is empty
// and the receiver waits for '$'.
module tagged_frame_receiver_xor_check
  import tfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] frame_status, [9:2] computed_xor, [17:10] received_checksum,
  // [23:18] updated_mask, [24] device_id_seen, [56:25] tcob_text,
  // [88:57] tceb_text, [120:89] stob_text, [152:121] steb_text,
  // [184:153] data_text, [191:185] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic          fire;
  logic [7:0]    rx_byte;
  tfr_phase_e    phase_q, phase_nx, phase_d;
  logic [6:0]    count_q, count_inc;
  logic          cr_q;
  logic          ends;
  logic [7:0]    xor_q, xor_nx;
  logic [7:0]    cks_q, cks_nx;
  tfr_tok_ctrl_t tok;
  tfr_vals_t     shadow_vals;
  logic [5:0]    shadow_mask;
  tfr_status_e   status;
  logic [5:0]    commit_mask;

  tfr_vals_t     committed_q;
  logic          id_seen_q;
  logic          out_valid_q;
  tfr_status_e   out_status_q;
  logic [7:0]    out_xor_q;
  logic [7:0]    out_cks_q;
  logic [5:0]    out_mask_q;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  assign count_inc = count_q + 7'd1;
  assign ends = (rx_byte == CH_LF && cr_q) || (count_inc >= 7'(MAX_FRAME_BYTES));

  // next phase
  always_comb begin
    phase_nx = phase_q;
    unique case (phase_q)
      PH_WAIT: if (rx_byte == CH_START) phase_nx = PH_BODY;
      PH_BODY: if (rx_byte == CH_END) phase_nx = PH_CKS;
      PH_CKS:  phase_nx = PH_DONE;
      PH_DONE: phase_nx = PH_DONE;
      default: phase_nx = PH_WAIT;
    endcase
    phase_d = ends ? PH_WAIT : phase_nx;
  end

  // per-phase datapath controls
  always_comb begin
    xor_nx     = xor_q;
    cks_nx     = cks_q;
    tok.take   = 1'b0;
    tok.finish = 1'b0;
    tok.clear  = fire && ends;
    unique case (phase_q)
      PH_BODY: begin
        if (rx_byte == CH_END) begin
          tok.finish = fire;
        end else begin
          xor_nx = xor_q ^ rx_byte;
          if (rx_byte == CH_SEP) tok.finish = fire;
          else tok.take = fire;
        end
      end
      PH_CKS:  cks_nx = rx_byte;
      default: ;
    endcase
  end

  tfr_shadow u_shadow (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (rx_byte),
    .ctrl_i (tok),
    .vals_o (shadow_vals),
    .mask_o (shadow_mask)
  );

  always_comb begin
    commit_mask = '0;
    priority if (phase_nx != PH_DONE) begin
      status = ST_MISSING;
    end else if (cks_nx != xor_nx) begin
      status = ST_MISMATCH;
    end else begin
      status      = ST_OK;
      commit_mask = shadow_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      count_q <= '0;
      cr_q    <= 1'b0;
      xor_q   <= '0;
      cks_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      cr_q    <= ends ? 1'b0 : (rx_byte == CH_CR);
      count_q <= ends ? 7'd0 : count_inc;
      xor_q   <= ends ? 8'd0 : xor_nx;
      cks_q   <= ends ? 8'd0 : cks_nx;
    end
  end

  // commit the shadow values on a good frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= '0;
      id_seen_q   <= 1'b0;
    end else if (fire && ends) begin
      if (commit_mask[0]) id_seen_q <= 1'b1;
      for (int k = 0; k < NUM_VALS; k++) begin
        if (commit_mask[k + 1]) committed_q[k] <= shadow_vals[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && ends) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ends) begin
      out_status_q <= status;
      out_xor_q    <= xor_nx;
      out_cks_q    <= cks_nx;
      out_mask_q   <= commit_mask;
    end
  end

  // committed values change only when a new word loads, so drive them directly
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, committed_q, id_seen_q, out_mask_q, out_cks_q,
                          out_xor_q, out_status_q};

endmodule

// ----- src/tfr_checker.sv -----
module tfr_checker
  import tfr_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [1:0] status;
  logic [5:0] mask;

  assign status = m_axis_tdata[1:0];
  assign mask   = m_axis_tdata[23:18];

  // a waiting status word blocks the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while status word stalled");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled status word changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> status == ST_OK || status == ST_MISMATCH || status == ST_MISSING)
    else $error("bad frame status");

  a_mask_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status != ST_OK |-> mask == 6'd0)
    else $error("update mask set on a failed frame");

  a_id_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mask[0] |-> m_axis_tdata[24])
    else $error("identifier committed but flag clear");

endmodule

bind tagged_frame_receiver_xor_check tfr_checker u_tfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/tagged_frame_receiver_xor_check_tb.sv -----
`timescale 1ns / 1ps

module tagged_frame_receiver_xor_check_tb;
  import tfr_pkg::*;

  typedef struct packed {
    tfr_status_e status;
    logic [7:0]  frame_xor;
    logic [7:0]  rx_cks;
    logic [5:0]  mask;
    logic        id_seen;
    tfr_vals_t   texts;
  } frame_result_t;

  typedef enum int {
    FR_GOOD,
    FR_NO_END,
    FR_CR_CKS,
    FR_NOISE
  } frame_kind_e;

  // Tracks the receiver state and queues one status word per frame end.
  class frame_scoreboard;
    tfr_phase_e      phase;
    logic [6:0]      count;
    logic            last_cr;
    logic [7:0]      body_xor;
    logic [7:0]      cks;
    logic [3:0]      tok_pos;
    logic [31:0]     tag;
    logic [31:0]     val;
    tfr_vals_t       shadow;
    logic [5:0]      shadow_mask;
    tfr_vals_t       held;
    logic            id_flag;
    frame_result_t   status_q[$];
    int              errors;
    int              words;

    function new();
      clear_frame();
      held    = '0;
      id_flag = 1'b0;
      errors  = 0;
      words   = 0;
    endfunction

    function void clear_token();
      tok_pos = '0;
      tag     = '0;
      val     = '0;
    endfunction

    function void clear_frame();
      phase       = PH_WAIT;
      count       = '0;
      last_cr     = 1'b0;
      body_xor    = '0;
      cks         = '0;
      shadow      = '0;
      shadow_mask = '0;
      clear_token();
    endfunction

    function void close_token();
      if (tok_pos >= 4) begin
        if (tag == TAG_ID) begin
          shadow_mask[0] = 1'b1;
        end else begin
          for (int k = 0; k < NUM_VALS; k++) begin
            if (tag == VALUE_TAGS[k]) begin
              shadow[k]          = val;
              shadow_mask[k + 1] = 1'b1;
            end
          end
        end
      end
      clear_token();
    endfunction

    function void take_char(logic [7:0] b);
      int p;
      p = int'(tok_pos);
      if (p < 4) tag[8 * (3 - p) +: 8] = b;
      else if (p >= 5 && p <= 8) val[8 * (8 - p) +: 8] = b;
      if (tok_pos < 9) tok_pos++;
    endfunction

    function void note_byte(logic [7:0] b);
      logic          ends;
      frame_result_t r;
      case (phase)
        PH_WAIT: begin
          if (b == CH_START) phase = PH_BODY;
        end
        PH_BODY: begin
          if (b == CH_END) begin
            close_token();
            phase = PH_CKS;
          end else begin
            body_xor ^= b;
            if (b == CH_SEP) close_token();
            else take_char(b);
          end
        end
        PH_CKS: begin
          cks   = b;
          phase = PH_DONE;
        end
        default: ;
      endcase
      count   = count + 7'd1;
      ends    = (b == CH_LF && last_cr) || (count >= MAX_FRAME_BYTES);
      last_cr = (b == CH_CR);
      if (!ends) return;

      r.mask = '0;
      if (phase != PH_DONE) begin
        r.status = ST_MISSING;
      end else if (cks != body_xor) begin
        r.status = ST_MISMATCH;
      end else begin
        r.status = ST_OK;
        r.mask   = shadow_mask;
        if (shadow_mask[0]) id_flag = 1'b1;
        for (int k = 0; k < NUM_VALS; k++)
          if (shadow_mask[k + 1]) held[k] = shadow[k];
      end
      r.frame_xor = body_xor;
      r.rx_cks    = cks;
      r.id_seen   = id_flag;
      r.texts     = held;
      status_q.push_back(r);
      clear_frame();
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    task report(input string msg);
      $display("ERROR word %0d: %s", words, msg);
      errors++;
    endtask

    task check_word(input logic [OUT_DATA_W-1:0] d);
      frame_result_t e;
      words++;
      if (status_q.size() == 0) begin
        report("status word with no frame end pending");
        return;
      end
      e = status_q.pop_front();
      if (d[1:0] != e.status)
        report($sformatf("frame_status got %0d want %0d", d[1:0], e.status));
      if (d[9:2] != e.frame_xor)
        report($sformatf("computed_xor got %h want %h", d[9:2], e.frame_xor));
      if (d[17:10] != e.rx_cks)
        report($sformatf("received_checksum got %h want %h", d[17:10], e.rx_cks));
      if (d[23:18] != e.mask)
        report($sformatf("updated_mask got %h want %h", d[23:18], e.mask));
      if (d[24] != e.id_seen)
        report($sformatf("device_id_seen got %0d want %0d", d[24], e.id_seen));
      for (int k = 0; k < NUM_VALS; k++)
        if (d[25 + 32 * k +: 32] != e.texts[k])
          report($sformatf("text %0d got %h want %h", k, d[25 + 32 * k +: 32],
                           e.texts[k]));
      if (d[OUT_DATA_W-1:185] != '0)
        report($sformatf("pad bits got %h", d[OUT_DATA_W-1:185]));
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  frame_scoreboard board;
  logic [7:0]      frame_q[$];
  logic [7:0]      body_acc;
  int              src_idle_pct  = 0;
  int              sink_stall_pct = 0;

  tagged_frame_receiver_xor_check uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
  end

  // Any byte but the frame markers and CR; '$' stays in as body data.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = $urandom_range(1) ? 8'($urandom_range(32, 126)) : 8'($urandom);
    if (c == CH_END || c == CH_SEP || c == CH_CR) c = 8'h5F;
    return c;
  endfunction

  function automatic logic [7:0] xor_str(input string s);
    logic [7:0] x;
    x = '0;
    foreach (s[i]) x ^= s[i];
    return x;
  endfunction

  task automatic push_str(input string s);
    foreach (s[i]) frame_q.push_back(s[i]);
  endtask

  task automatic add_body(input logic [7:0] c);
    frame_q.push_back(c);
    body_acc ^= c;
  endtask

  task automatic build_frame(input frame_kind_e kind);
    int          ntok;
    int          tok_kind;
    logic [7:0]  c;
    logic [31:0] tg;
    frame_q.delete();
    body_acc = '0;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 130)) begin
        c = 8'($urandom);
        if ($urandom_range(9) < 3) begin
          case ($urandom_range(4))
            0: c = CH_START;
            1: c = CH_END;
            2: c = CH_SEP;
            3: c = CH_CR;
            default: c = CH_LF;
          endcase
        end
        frame_q.push_back(c);
      end
      return;
    end

    // leading junk, '*' included
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        c = body_char();
        if (c == CH_START) c = CH_END;
        frame_q.push_back(c);
      end
    end
    frame_q.push_back(CH_START);

    ntok = $urandom_range(0, 6);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) add_body(CH_SEP);
      tok_kind = $urandom_range(9);
      if (tok_kind < 6) begin
        tg = (tok_kind == 0) ? TAG_ID : VALUE_TAGS[tok_kind - 1];
        for (int i = 3; i >= 0; i--) add_body(tg[8 * i +: 8]);
      end else if (tok_kind == 6) begin
        repeat (4) add_body(body_char());
      end else if (tok_kind == 7) begin
        repeat ($urandom_range(1, 3)) add_body(body_char());
      end
      if (tok_kind <= 6) begin
        add_body(($urandom_range(3) == 0) ? body_char() : 8'h2C);
        repeat ($urandom_range(0, 6)) add_body(body_char());
      end
    end

    if (kind != FR_NO_END) begin
      frame_q.push_back(CH_END);
      if (kind == FR_GOOD) begin
        c = body_acc;
        if ($urandom_range(6) == 0) c ^= 8'($urandom_range(1, 255));
        frame_q.push_back(c);
        if ($urandom_range(6) == 0)
          repeat ($urandom_range(1, 2)) frame_q.push_back(body_char());
      end
    end
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(b);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  // Drop valid and hold until every status word is out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    #(5_000_000);
    $display("FAIL tagged_frame_receiver_xor_check");
    $finish;
  end

  initial begin
    int          sent;
    int          r;
    frame_kind_e kind;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // star before dollar, short value, empty token, id tag; then a CR
    // checksum byte and a bare CR LF
    frame_q.delete();
    frame_q.push_back(8'hFF);
    push_str("*$TCOB,12;;OBC4*");
    frame_q.push_back(xor_str("TCOB,12;;OBC4"));
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
    frame_q.push_back(CH_START);
    frame_q.push_back(8'h00);
    frame_q.push_back(CH_END);
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
    send_frame();

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      sent = 0;
      while (sent < 475) begin
        r = $urandom_range(99);
        if (r < 72) kind = FR_GOOD;
        else if (r < 80) kind = FR_NO_END;
        else if (r < 86) kind = FR_CR_CKS;
        else kind = FR_NOISE;
        build_frame(kind);
        sent += frame_q.size();
        send_frame();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASS tagged_frame_receiver_xor_check");
    end else begin
      $display("FAIL tagged_frame_receiver_xor_check");
    end
    $finish;
  end

endmodule
